### rtl/svpwm_pkg.sv
// Package: shared types, constants and sine table function for the SVPWM duty generator.
package svpwm_pkg;

	localparam logic [15:0] DEPTH_CLAMP_Q16 = 16'd37814;
	localparam logic [16:0] SQRT3_Q16       = 17'd113512;
	localparam logic [16:0] ONE_Q16         = 17'd65536;
	localparam logic [15:0] PWM_PERIOD_RST  = 16'd8000;
	localparam logic [14:0] SUPPLY_RST      = 15'd3072;
	localparam logic [16:0] RECIP3_Q17      = 17'd43691;
	localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;

	typedef enum logic [1:0] {
		REG_PWM_PERIOD     = 2'd0,
		REG_SUPPLY_VOLTAGE = 2'd1
	} reg_index_t;

	typedef struct packed {
		logic [2:0]  sec;
		logic [16:0] k1;
		logic [16:0] k2;
	} side_t;

	// advance a Taylor term by r squared, Q30, before its factorial divide
	function automatic longint unsigned taylor_next(input longint unsigned term,
		input longint unsigned r);
		longint unsigned t;
		t = (term * r) >> 30;
		return (t * r) >> 30;
	endfunction

endpackage

### rtl/svpwm_duty_generator.sv
// Top level: pipelined space vector PWM duty generator.
// One item enters per clock and one result leaves per clock while the output is not stalled.
// The 16-stage square root and 17-stage divider form the modulation depth. A stall on the
// output freezes the whole pipeline, so the input stalls only while a finished result waits
// and the output is stalled. No state is kept between items. The user must write pwm_period
// and supply_voltage through the configuration port only while idle, unenforced by the block.
module svpwm_duty_generator #(
	parameter int ANGLE_BITS       = 16,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] volt_q,
	input  logic signed [15:0] volt_d,
	input  logic [15:0]        elec_angle,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        duty_a,
	output logic [15:0]        duty_b,
	output logic [15:0]        duty_c,
	output logic [2:0]         sector_out
);

	localparam int AB = ANGLE_BITS;
	localparam int D  = SINE_TABLE_DEPTH;
	localparam int IW = $clog2(D);
	localparam logic [16:0] TWO_D   = 17'(2 * D);
	localparam logic [16:0] D_LAST  = 17'(D - 1);
	localparam logic [16:0] D_W     = 17'(D);

	logic [15:0] pwm_period_q;
	logic [14:0] supply_voltage_q;
	logic        adv;

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q     <= svpwm_pkg::PWM_PERIOD_RST;
			supply_voltage_q <= svpwm_pkg::SUPPLY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				svpwm_pkg::REG_PWM_PERIOD:     pwm_period_q <= cfg_wdata;
				svpwm_pkg::REG_SUPPLY_VOLTAGE: supply_voltage_q <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	logic [16:0] sine_rom [D];
	for (genvar k = 0; k < D; k++) begin : g_rom
		localparam longint unsigned R  = (64'(k) * svpwm_pkg::TWO_PI_Q30) / (64'(4 * D));
		localparam longint unsigned T1 = svpwm_pkg::taylor_next(R, R) / 64'd6;
		localparam longint unsigned T2 = svpwm_pkg::taylor_next(T1, R) / 64'd20;
		localparam longint unsigned T3 = svpwm_pkg::taylor_next(T2, R) / 64'd42;
		localparam longint unsigned T4 = svpwm_pkg::taylor_next(T3, R) / 64'd72;
		localparam longint unsigned T5 = svpwm_pkg::taylor_next(T4, R) / 64'd110;
		localparam longint unsigned T6 = svpwm_pkg::taylor_next(T5, R) / 64'd156;
		localparam longint unsigned T7 = svpwm_pkg::taylor_next(T6, R) / 64'd210;
		localparam longint unsigned S1 = (R >= T1) ? R - T1 : 64'd0;
		localparam longint unsigned S2 = S1 + T2;
		localparam longint unsigned S3 = (S2 >= T3) ? S2 - T3 : 64'd0;
		localparam longint unsigned S4 = S3 + T4;
		localparam longint unsigned S5 = (S4 >= T5) ? S4 - T5 : 64'd0;
		localparam longint unsigned S6 = S5 + T6;
		localparam longint unsigned S7 = (S6 >= T7) ? S6 - T7 : 64'd0;
		localparam longint unsigned ENTRY = (S7 + 64'd8192) >> 14;
		assign sine_rom[k] = 17'(ENTRY);
	end

	logic [AB-1:0] ang_in;
	if (AB >= 16) begin : g_ang_wide
		assign ang_in = AB'(elec_angle);
	end else begin : g_ang_narrow
		assign ang_in = elec_angle[AB-1:0];
	end

	// stage 1: capture
	logic               v_s1;
	logic signed [15:0] q_s1, d_s1;
	logic [AB-1:0]      ang_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			q_s1   <= volt_q;
			d_s1   <= volt_d;
			ang_s1 <= ang_in;
		end
	end

	// stage 2: squares, sector split
	logic          v_s2;
	logic [30:0]   qq_s2, dd_s2;
	logic [2:0]    sec_s2;
	logic [AB-1:0] f_s2;
	logic signed [31:0] qq_w, dd_w;
	logic [AB-1:0] a_w;
	logic [AB+2:0] a6_w;

	always_comb begin
		qq_w = q_s1 * q_s1;
		dd_w = d_s1 * d_s1;
		a_w  = ang_s1 + AB'(1 << (AB - 2));
		a6_w = (AB+3)'(a_w) * (AB+3)'(6);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			qq_s2  <= qq_w[30:0];
			dd_s2  <= dd_w[30:0];
			sec_s2 <= a6_w[AB+2:AB];
			f_s2   <= a6_w[AB-1:0];
		end
	end

	// stage 3: sum of squares, table indexes
	logic          v_s3;
	logic [31:0]   sum_s3;
	logic [2:0]    sec_s3;
	logic [IW-1:0] idx1_s3, idx2_s3;
	logic [AB:0]   pos1_w, pos2_w;
	logic [AB+16:0] prod1_w, prod2_w;
	logic [33:0]   y31_w, y32_w;
	logic [16:0]   ix1_w, ix2_w;

	always_comb begin
		pos1_w  = (AB+1)'(1 << AB) - (AB+1)'(f_s2);
		pos2_w  = (AB+1)'(f_s2);
		prod1_w = (AB+17)'(pos1_w) * (AB+17)'(TWO_D);
		prod2_w = (AB+17)'(pos2_w) * (AB+17)'(TWO_D);
		y31_w   = 34'(prod1_w[AB+16:AB]) * 34'(svpwm_pkg::RECIP3_Q17);
		y32_w   = 34'(prod2_w[AB+16:AB]) * 34'(svpwm_pkg::RECIP3_Q17);
		ix1_w   = y31_w[33:17];
		ix2_w   = y32_w[33:17];
		if (ix1_w >= D_W) ix1_w = D_LAST;
		if (ix2_w >= D_W) ix2_w = D_LAST;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3  <= {1'b0, qq_s2} + {1'b0, dd_s2};
			sec_s3  <= sec_s2;
			idx1_s3 <= ix1_w[IW-1:0];
			idx2_s3 <= ix2_w[IW-1:0];
		end
	end

	// stage 4: table read
	logic        v_s4;
	logic [31:0] sum_s4;
	logic [2:0]  sec_s4;
	logic [16:0] sin1_s4, sin2_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s4  <= sum_s3;
			sec_s4  <= sec_s3;
			sin1_s4 <= sine_rom[idx1_s3];
			sin2_s4 <= sine_rom[idx2_s3];
		end
	end

	// stage 5: sqrt3 scaling
	logic             v_s5;
	logic [31:0]      sum_s5;
	svpwm_pkg::side_t side_s5;
	logic [33:0]      k1_w, k2_w;

	always_comb begin
		k1_w = 34'(sin1_s4) * 34'(svpwm_pkg::SQRT3_Q16);
		k2_w = 34'(sin2_s4) * 34'(svpwm_pkg::SQRT3_Q16);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s5      <= sum_s4;
			side_s5.sec <= sec_s4;
			side_s5.k1  <= k1_w[32:16];
			side_s5.k2  <= k2_w[32:16];
		end
	end

	// square root, one result bit per stage
	logic             sq_v_s    [17];
	logic [31:0]      sq_rem_s  [17];
	logic [15:0]      sq_root_s [17];
	svpwm_pkg::side_t sq_side_s [17];

	assign sq_v_s[0]    = v_s5;
	assign sq_rem_s[0]  = sum_s5;
	assign sq_root_s[0] = '0;
	assign sq_side_s[0] = side_s5;

	for (genvar i = 0; i < 16; i++) begin : g_sqrt
		localparam int B = 15 - i;
		logic [32:0] delta;
		logic        take;
		assign delta = (33'(sq_root_s[i]) << (B + 1)) + (33'd1 << (2 * B));
		assign take  = {1'b0, sq_rem_s[i]} >= delta;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v_s[i+1] <= 1'b0;
			else if (adv) sq_v_s[i+1] <= sq_v_s[i];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rem_s[i+1]  <= take ? 32'({1'b0, sq_rem_s[i]} - delta) : sq_rem_s[i];
				sq_root_s[i+1] <= take ? (sq_root_s[i] | (16'd1 << B)) : sq_root_s[i];
				sq_side_s[i+1] <= sq_side_s[i];
			end
		end
	end

	// divider setup
	logic             su_v_s, su_sat_s, su_nb_s;
	logic [14:0]      su_rem_s;
	svpwm_pkg::side_t su_side_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) su_v_s <= 1'b0;
		else if (adv) su_v_s <= sq_v_s[16];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			su_sat_s  <= {1'b0, sq_root_s[16]} >= {1'b0, supply_voltage_q, 1'b0};
			su_rem_s  <= sq_root_s[16][15:1];
			su_nb_s   <= sq_root_s[16][0];
			su_side_s <= sq_side_s[16];
		end
	end

	// restoring divider, one quotient bit per stage
	logic             dv_v_s    [18];
	logic             dv_sat_s  [18];
	logic [14:0]      dv_rem_s  [18];
	logic [16:0]      dv_quo_s  [18];
	svpwm_pkg::side_t dv_side_s [18];

	assign dv_v_s[0]    = su_v_s;
	assign dv_sat_s[0]  = su_sat_s;
	assign dv_rem_s[0]  = su_rem_s;
	assign dv_quo_s[0]  = '0;
	assign dv_side_s[0] = su_side_s;

	for (genvar j = 0; j < 17; j++) begin : g_div
		logic        nb;
		logic [15:0] tr;
		logic        ge;
		logic [15:0] diff;
		assign nb   = (j == 0) ? su_nb_s : 1'b0;
		assign tr   = {dv_rem_s[j], nb};
		assign ge   = tr >= {1'b0, supply_voltage_q};
		assign diff = tr - {1'b0, supply_voltage_q};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[j+1] <= 1'b0;
			else if (adv) dv_v_s[j+1] <= dv_v_s[j];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_sat_s[j+1]  <= dv_sat_s[j];
				dv_rem_s[j+1]  <= ge ? diff[14:0] : tr[14:0];
				dv_quo_s[j+1]  <= {dv_quo_s[j][15:0], ge};
				dv_side_s[j+1] <= dv_side_s[j];
			end
		end
	end

	// depth clamp
	logic             dp_v_s;
	logic [15:0]      dp_depth_s;
	svpwm_pkg::side_t dp_side_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dp_v_s <= 1'b0;
		else if (adv) dp_v_s <= dv_v_s[17];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			dp_depth_s <= (dv_sat_s[17] || dv_quo_s[17] > 17'(svpwm_pkg::DEPTH_CLAMP_Q16))
				? svpwm_pkg::DEPTH_CLAMP_Q16 : dv_quo_s[17][15:0];
			dp_side_s  <= dv_side_s[17];
		end
	end

	// active times
	logic        tm_v_s;
	logic [16:0] tm_t1_s, tm_t2_s;
	logic [2:0]  tm_sec_s;
	logic [32:0] t1_w, t2_w;

	always_comb begin
		t1_w = 33'(dp_side_s.k1) * 33'(dp_depth_s);
		t2_w = 33'(dp_side_s.k2) * 33'(dp_depth_s);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tm_v_s <= 1'b0;
		else if (adv) tm_v_s <= dp_v_s;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			tm_t1_s  <= t1_w[32:16];
			tm_t2_s  <= t2_w[32:16];
			tm_sec_s <= dp_side_s.sec;
		end
	end

	// zero time split and per-sector arrangement
	logic        ar_v_s;
	logic [16:0] ar_ta_s, ar_tb_s, ar_tc_s;
	logic [2:0]  ar_sec_s;
	logic [17:0] s12_w, t0_w, half_w, ta_w, tb_w, tc_w, p1_w, p2_w, p12_w;

	function automatic logic [16:0] clamp_one(input logic [17:0] t);
		return (t > 18'(svpwm_pkg::ONE_Q16)) ? svpwm_pkg::ONE_Q16 : t[16:0];
	endfunction

	always_comb begin
		s12_w  = 18'(tm_t1_s) + 18'(tm_t2_s);
		t0_w   = (s12_w >= 18'(svpwm_pkg::ONE_Q16)) ? 18'd0 : 18'(svpwm_pkg::ONE_Q16) - s12_w;
		half_w = t0_w >> 1;
		p1_w   = 18'(tm_t1_s) + half_w;
		p2_w   = 18'(tm_t2_s) + half_w;
		p12_w  = s12_w + half_w;
		unique case (tm_sec_s)
			3'd0: begin ta_w = p12_w;  tb_w = p2_w;   tc_w = half_w; end
			3'd1: begin ta_w = p1_w;   tb_w = p12_w;  tc_w = half_w; end
			3'd2: begin ta_w = half_w; tb_w = p12_w;  tc_w = p2_w;   end
			3'd3: begin ta_w = half_w; tb_w = p1_w;   tc_w = p12_w;  end
			3'd4: begin ta_w = p2_w;   tb_w = half_w; tc_w = p12_w;  end
			default: begin ta_w = p12_w; tb_w = half_w; tc_w = p1_w; end
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ar_v_s <= 1'b0;
		else if (adv) ar_v_s <= tm_v_s;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ar_ta_s  <= clamp_one(ta_w);
			ar_tb_s  <= clamp_one(tb_w);
			ar_tc_s  <= clamp_one(tc_w);
			ar_sec_s <= tm_sec_s;
		end
	end

	// scale by period into the output register
	logic        out_v_q;
	logic [15:0] duty_a_q, duty_b_q, duty_c_q;
	logic [2:0]  sector_q;
	logic [32:0] da_w, db_w, dc_w;

	always_comb begin
		da_w = 33'(ar_ta_s) * 33'(pwm_period_q);
		db_w = 33'(ar_tb_s) * 33'(pwm_period_q);
		dc_w = 33'(ar_tc_s) * 33'(pwm_period_q);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (adv) out_v_q <= ar_v_s;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			duty_a_q <= da_w[31:16];
			duty_b_q <= db_w[31:16];
			duty_c_q <= dc_w[31:16];
			sector_q <= ar_sec_s + 3'd1;
		end
	end

	assign out_valid  = out_v_q;
	assign duty_a     = duty_a_q;
	assign duty_b     = duty_b_q;
	assign duty_c     = duty_c_q;
	assign sector_out = sector_q;

endmodule

### rtl/svpwm_checker.sv
// Checker: port-level assertions for the SVPWM duty generator, bound to the top level.
module svpwm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] duty_a,
	input logic [15:0] duty_b,
	input logic [15:0] duty_c,
	input logic [2:0]  sector_out
);

	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sector_out >= 3'd1 && sector_out <= 3'd6))
		else $error("sector out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a waiting result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(duty_a) && $stable(duty_b)
			&& $stable(duty_c) && $stable(sector_out)))
		else $error("stalled result changed");

	a_no_stall_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output free");

endmodule

bind svpwm_duty_generator svpwm_checker u_svpwm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.duty_a     (duty_a),
	.duty_b     (duty_b),
	.duty_c     (duty_c),
	.sector_out (sector_out)
);
